// File: sv/rms_envelope_lipsync_drive_macros.svh
// Assertion macros for the lip-sync envelope block.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef RMS_ENVELOPE_LIPSYNC_DRIVE_MACROS_SVH
`define RMS_ENVELOPE_LIPSYNC_DRIVE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RMSLD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RMSLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rmsld_pkg.sv
// Shared constants, codes and types of the lip-sync envelope block.
// No dependencies; used by rmsld_serial_alu and the top level.
`timescale 1ns / 1ps
package rmsld_pkg;

  localparam int MAX_BLOCK_DEF = 1024;

  localparam int ONE_Q16  = 65536;
  localparam int BASE_MAX = 8388607;
  localparam int HALF_LSB = 32768;
  // Smallest position or openness that gives a nonzero duty.
  localparam int POS_MIN  = (ONE_Q16 + 99) / 100;
  localparam int OPEN_MIN = (ONE_Q16 + 19) / 20;

  localparam int ACC_W = 42;
  localparam int B_W   = 24;
  localparam int REM_W = 24;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_STOP   = 2'd1;
  localparam logic [1:0] MODE_POS    = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_A   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX = 3'd6;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
    logic       keep;
  } alu_cmd_t;

endpackage

// File: sv/rmsld_serial_alu.sv
// Bit-serial arithmetic unit: shift-add multiply-accumulate, restoring
// divide and digit-by-digit square root, one bit or bit pair per cycle.
// Depends on rmsld_pkg.
`timescale 1ns / 1ps
module rmsld_serial_alu #(
  parameter int OP_W = 42
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rmsld_pkg::alu_cmd_t           cmd,
  input  logic [OP_W-1:0]               opa,
  input  logic [rmsld_pkg::B_W-1:0]     opb,
  output logic                          done,
  output logic [rmsld_pkg::ACC_W-1:0]   acc,
  output logic [OP_W-1:0]               quot,
  output logic [rmsld_pkg::B_W-1:0]     root
);
  import rmsld_pkg::*;

  localparam int CNT_W = $clog2(OP_W);

  // x: multiplicand / dividend-quotient / radicand; y: multiplier / divisor / root
  logic [OP_W-1:0]  x_r, x_nxt;
  logic [B_W-1:0]   y_r, y_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       op_r, op_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [REM_W:0]   rem_d;
  logic [REM_W+1:0] rem_s;
  logic [B_W+1:0]   trial;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_d    = {acc_r[REM_W-1:0], x_r[OP_W-1]};
    rem_s    = {acc_r[REM_W-1:0], x_r[OP_W-1 -: 2]};
    trial    = {y_r, 2'b01};
    if (cmd.start) begin
      op_nxt   = cmd.op;
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = opa;
      y_nxt    = (cmd.op == OP_SQRT) ? '0 : opb;
      acc_nxt  = (cmd.op == OP_MUL && cmd.keep) ? acc_r : '0;
    end else if (busy_r) begin
      unique case (op_r)
        OP_MUL: begin
          if (y_r == '0) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else begin
            acc_nxt = acc_r + (y_r[0] ? x_r[ACC_W-1:0] : '0);
            x_nxt   = {x_r[OP_W-2:0], 1'b0};
            y_nxt   = {1'b0, y_r[B_W-1:1]};
          end
        end
        OP_DIV: begin
          if (rem_d >= {1'b0, y_r}) begin
            acc_nxt = ACC_W'(rem_d - {1'b0, y_r});
            x_nxt   = {x_r[OP_W-2:0], 1'b1};
          end else begin
            acc_nxt = ACC_W'(rem_d);
            x_nxt   = {x_r[OP_W-2:0], 1'b0};
          end
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(OP_W - 1)) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        OP_SQRT: begin
          if (rem_s >= trial) begin
            acc_nxt = ACC_W'(rem_s - trial);
            y_nxt   = {y_r[B_W-2:0], 1'b1};
          end else begin
            acc_nxt = ACC_W'(rem_s);
            y_nxt   = {y_r[B_W-2:0], 1'b0};
          end
          x_nxt   = {x_r[OP_W-3:0], 2'b00};
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(OP_W / 2 - 1)) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign acc  = acc_r;
  assign quot = x_r;
  assign root = y_r;

endmodule

// File: sv/rms_envelope_lipsync_drive.sv
// RMS envelope follower for a lip-sync mouth motor. Audio samples (mode 0)
// are squared and summed; the beat marked last closes the block and yields
// one result: block RMS, smoothed openness and a forward PWM duty. Mode 1
// clears sum, count, baseline and openness and returns zeros, mode 2 maps a
// direct position to a duty, mode 3 is dropped. Sample, block-end and
// direct-position work goes through one bit-serial unit (shift-add multiply,
// restoring divide, square root). A sample beat runs one multiply while the
// block has room. A block end then runs a divide of the sum by the count
// (skipped for an empty block), a square root, up to six multiplies and a
// divide for the target. A direct-position beat runs at most one multiply.
// Input is taken only while the sequencer is idle; a finished result sits
// in the output register while the next beat is accepted.
// Depends on rmsld_pkg, rmsld_serial_alu and the macros header.
`timescale 1ns / 1ps
`include "rms_envelope_lipsync_drive_macros.svh"
module rms_envelope_lipsync_drive #(
  parameter int MAX_BLOCK = rmsld_pkg::MAX_BLOCK_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_mode,
  input  logic signed [15:0]                in_sample,
  input  logic                              in_last,
  input  logic [16:0]                       in_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_mouth_duty,
  output logic [15:0]                       out_rms_level,
  output logic [16:0]                       out_openness_level,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rmsld_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [16:0]                       cfg_data
);
  import rmsld_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W = 30 + CNT_W;
  localparam int RAW_W = (SUM_W > ACC_W) ? SUM_W : ACC_W;
  localparam int OP_W  = RAW_W + (RAW_W % 2);

  // Sequencer states; the *_W states wait for the serial unit.
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_SQ_W   = 5'd1;
  localparam logic [4:0] ST_BLK    = 5'd2;
  localparam logic [4:0] ST_MEAN_W = 5'd3;
  localparam logic [4:0] ST_ROOT_W = 5'd4;
  localparam logic [4:0] ST_BASE   = 5'd5;
  localparam logic [4:0] ST_BM1_W  = 5'd6;
  localparam logic [4:0] ST_BM2_W  = 5'd7;
  localparam logic [4:0] ST_TGT    = 5'd8;
  localparam logic [4:0] ST_THR_W  = 5'd9;
  localparam logic [4:0] ST_TDIV_W = 5'd10;
  localparam logic [4:0] ST_OPEN   = 5'd11;
  localparam logic [4:0] ST_OM1_W  = 5'd12;
  localparam logic [4:0] ST_OM2_W  = 5'd13;
  localparam logic [4:0] ST_LVL    = 5'd14;
  localparam logic [4:0] ST_DUTY_W = 5'd15;
  localparam logic [4:0] ST_EMIT   = 5'd16;

  // Configuration registers.
  logic [15:0] silence_r, ratio_r;
  logic [16:0] base_a_r, attack_r, release_r;
  logic [7:0]  duty_min_r, duty_max_r;

  // Block state.
  logic [4:0]       st_r, st_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [22:0]      baseline_r, baseline_nxt;
  logic [16:0]      openness_r, openness_nxt;
  logic             last_r, last_nxt;
  logic [15:0]      rms_r, rms_nxt;
  logic [16:0]      target_r, target_nxt;
  logic [16:0]      alpha_r, alpha_nxt;
  logic [7:0]       duty_r, duty_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_duty_r, out_duty_nxt;
  logic [15:0] out_rms_r, out_rms_nxt;
  logic [16:0] out_open_r, out_open_nxt;

  // Serial unit launch registers.
  alu_cmd_t        cmd_r, cmd_nxt;
  logic [OP_W-1:0] opa_r, opa_nxt;
  logic [B_W-1:0]  opb_r, opb_nxt;
  logic             alu_done;
  logic [ACC_W-1:0] alu_acc;
  logic [OP_W-1:0]  alu_quot;
  logic [B_W-1:0]   alu_root;

  logic [15:0]      mag;
  logic [16:0]      pos_c;
  logic [16:0]      base_a_c;
  logic [16:0]      alpha_c;
  logic [7:0]       span;
  logic [ACC_W-1:0] mix_sum;
  logic [ACC_W-17:0] mix_q;
  logic [23:0]      rms_q8;
  logic [ACC_W-1:0] rms_q20;
  logic [ACC_W-1:0] excess;
  logic             in_fire;

  rmsld_serial_alu #(.OP_W(OP_W)) u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd_r),
    .opa  (opa_r),
    .opb  (opb_r),
    .done (alu_done),
    .acc  (alu_acc),
    .quot (alu_quot),
    .root (alu_root)
  );

  assign in_ready  = (st_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_r  <= 16'd200;
      base_a_r   <= 17'd1311;
      ratio_r    <= 16'd4915;
      attack_r   <= 17'd39322;
      release_r  <= 17'd9830;
      duty_min_r <= 8'd80;
      duty_max_r <= 8'd255;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SILENCE:  silence_r  <= cfg_data[15:0];
        CFG_BASE_A:   base_a_r   <= cfg_data;
        CFG_RATIO:    ratio_r    <= cfg_data[15:0];
        CFG_ATTACK:   attack_r   <= cfg_data;
        CFG_RELEASE:  release_r  <= cfg_data;
        CFG_DUTY_MIN: duty_min_r <= cfg_data[7:0];
        CFG_DUTY_MAX: duty_max_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // Magnitude of the sample; -32768 maps to 32768, which still fits.
    mag      = in_sample[15] ? 16'(-in_sample) : in_sample;
    pos_c    = (in_position > 17'(ONE_Q16)) ? 17'(ONE_Q16) : in_position;
    base_a_c = (base_a_r > 17'(ONE_Q16)) ? 17'(ONE_Q16) : base_a_r;
    span     = (duty_max_r >= duty_min_r) ? (duty_max_r - duty_min_r) : 8'd0;
    // Round and drop 16 fraction bits of a mix.
    mix_sum  = alu_acc + ACC_W'(HALF_LSB);
    mix_q    = mix_sum[ACC_W-1:16];
    rms_q8   = {rms_r, 8'd0};
    rms_q20  = ACC_W'({rms_r, 20'd0});
    excess   = rms_q20 - alu_acc;
    alpha_c  = (target_r > openness_r) ? attack_r : release_r;
    alpha_c  = (alpha_c > 17'(ONE_Q16)) ? 17'(ONE_Q16) : alpha_c;
  end

  always_comb begin
    st_nxt        = st_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    baseline_nxt  = baseline_r;
    openness_nxt  = openness_r;
    last_nxt      = last_r;
    rms_nxt       = rms_r;
    target_nxt    = target_r;
    alpha_nxt     = alpha_r;
    duty_nxt      = duty_r;
    out_valid_nxt = out_valid_r;
    out_duty_nxt  = out_duty_r;
    out_rms_nxt   = out_rms_r;
    out_open_nxt  = out_open_r;
    cmd_nxt       = '{start: 1'b0, op: OP_MUL, keep: 1'b0};
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;

    // Drop the output beat once taken.
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_mode)
            MODE_STOP: begin
              sum_nxt      = '0;
              count_nxt    = '0;
              baseline_nxt = '0;
              openness_nxt = '0;
              rms_nxt      = '0;
              duty_nxt     = '0;
              st_nxt       = ST_EMIT;
            end
            MODE_POS: begin
              rms_nxt = '0;
              if (pos_c < 17'(POS_MIN)) begin
                duty_nxt = '0;
                st_nxt   = ST_EMIT;
              end else begin
                cmd_nxt = '{start: 1'b1, op: OP_MUL, keep: 1'b0};
                opa_nxt = OP_W'(pos_c);
                opb_nxt = B_W'(span);
                st_nxt  = ST_DUTY_W;
              end
            end
            MODE_SAMPLE: begin
              last_nxt = in_last;
              if (count_r < CNT_W'(MAX_BLOCK)) begin
                cmd_nxt = '{start: 1'b1, op: OP_MUL, keep: 1'b0};
                opa_nxt = OP_W'(mag);
                opb_nxt = B_W'(mag);
                st_nxt  = ST_SQ_W;
              end else if (in_last) begin
                st_nxt = ST_BLK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SQ_W: begin
        if (alu_done) begin
          sum_nxt   = sum_r + SUM_W'(alu_acc);
          count_nxt = count_r + 1'b1;
          st_nxt    = last_r ? ST_BLK : ST_IDLE;
        end
      end
      ST_BLK: begin
        // Launch the mean; an empty block goes straight to a root of zero.
        if (count_r == '0) begin
          cmd_nxt = '{start: 1'b1, op: OP_SQRT, keep: 1'b0};
          opa_nxt = '0;
          st_nxt  = ST_ROOT_W;
        end else begin
          cmd_nxt = '{start: 1'b1, op: OP_DIV, keep: 1'b0};
          opa_nxt = OP_W'(sum_r);
          opb_nxt = B_W'(count_r);
          st_nxt  = ST_MEAN_W;
        end
        sum_nxt   = '0;
        count_nxt = '0;
      end
      ST_MEAN_W: begin
        if (alu_done) begin
          cmd_nxt = '{start: 1'b1, op: OP_SQRT, keep: 1'b0};
          opa_nxt = alu_quot;
          st_nxt  = ST_ROOT_W;
        end
      end
      ST_ROOT_W: begin
        if (alu_done) begin
          rms_nxt = alu_root[15:0];
          st_nxt  = ST_BASE;
        end
      end
      ST_BASE: begin
        // Seed the baseline on the first loud block, else average it in.
        if (baseline_r < 23'd256 && rms_r > silence_r) begin
          baseline_nxt = (rms_q8 > 24'(BASE_MAX)) ? 23'(BASE_MAX) : rms_q8[22:0];
          st_nxt       = ST_TGT;
        end else begin
          cmd_nxt = '{start: 1'b1, op: OP_MUL, keep: 1'b0};
          opa_nxt = OP_W'(rms_q8);
          opb_nxt = B_W'(base_a_c);
          st_nxt  = ST_BM1_W;
        end
      end
      ST_BM1_W: begin
        if (alu_done) begin
          cmd_nxt = '{start: 1'b1, op: OP_MUL, keep: 1'b1};
          opa_nxt = OP_W'(baseline_r);
          opb_nxt = B_W'(18'(ONE_Q16) - 18'(base_a_c));
          st_nxt  = ST_BM2_W;
        end
      end
      ST_BM2_W: begin
        if (alu_done) begin
          baseline_nxt = (mix_q > (ACC_W-16)'(BASE_MAX)) ? 23'(BASE_MAX) : mix_q[22:0];
          st_nxt       = ST_TGT;
        end
      end
      ST_TGT: begin
        if (rms_r < silence_r) begin
          target_nxt = '0;
          st_nxt     = ST_OPEN;
        end else begin
          cmd_nxt = '{start: 1'b1, op: OP_MUL, keep: 1'b0};
          opa_nxt = OP_W'(baseline_r);
          opb_nxt = B_W'(ratio_r);
          st_nxt  = ST_THR_W;
        end
      end
      ST_THR_W: begin
        if (alu_done) begin
          if (rms_q20 > alu_acc) begin
            if (baseline_r == '0) begin
              target_nxt = 17'(ONE_Q16);
              st_nxt     = ST_OPEN;
            end else begin
              cmd_nxt = '{start: 1'b1, op: OP_DIV, keep: 1'b0};
              opa_nxt = OP_W'({excess, 3'b000});
              opb_nxt = B_W'(baseline_r);
              st_nxt  = ST_TDIV_W;
            end
          end else begin
            target_nxt = '0;
            st_nxt     = ST_OPEN;
          end
        end
      end
      ST_TDIV_W: begin
        if (alu_done) begin
          target_nxt = (alu_quot > OP_W'(ONE_Q16)) ? 17'(ONE_Q16) : alu_quot[16:0];
          st_nxt     = ST_OPEN;
        end
      end
      ST_OPEN: begin
        alpha_nxt = alpha_c;
        cmd_nxt   = '{start: 1'b1, op: OP_MUL, keep: 1'b0};
        opa_nxt   = OP_W'(target_r);
        opb_nxt   = B_W'(alpha_c);
        st_nxt    = ST_OM1_W;
      end
      ST_OM1_W: begin
        if (alu_done) begin
          cmd_nxt = '{start: 1'b1, op: OP_MUL, keep: 1'b1};
          opa_nxt = OP_W'(openness_r);
          opb_nxt = B_W'(18'(ONE_Q16) - 18'(alpha_r));
          st_nxt  = ST_OM2_W;
        end
      end
      ST_OM2_W: begin
        if (alu_done) begin
          openness_nxt = (mix_q > (ACC_W-16)'(ONE_Q16)) ? 17'(ONE_Q16) : mix_q[16:0];
          st_nxt       = ST_LVL;
        end
      end
      ST_LVL: begin
        if (openness_r < 17'(OPEN_MIN)) begin
          duty_nxt = '0;
          st_nxt   = ST_EMIT;
        end else begin
          cmd_nxt = '{start: 1'b1, op: OP_MUL, keep: 1'b0};
          opa_nxt = OP_W'(openness_r);
          opb_nxt = B_W'(span);
          st_nxt  = ST_DUTY_W;
        end
      end
      ST_DUTY_W: begin
        if (alu_done) begin
          duty_nxt = duty_min_r + alu_acc[23:16];
          st_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hold until the output register is free, then load the beat.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_duty_nxt  = duty_r;
          out_rms_nxt   = rms_r;
          out_open_nxt  = openness_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      baseline_r  <= '0;
      openness_r  <= '0;
      out_valid_r <= 1'b0;
      cmd_r       <= '{start: 1'b0, op: OP_MUL, keep: 1'b0};
    end else begin
      st_r        <= st_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      baseline_r  <= baseline_nxt;
      openness_r  <= openness_nxt;
      out_valid_r <= out_valid_nxt;
      cmd_r       <= cmd_nxt;
    end
    last_r     <= last_nxt;
    rms_r      <= rms_nxt;
    target_r   <= target_nxt;
    alpha_r    <= alpha_nxt;
    duty_r     <= duty_nxt;
    out_duty_r <= out_duty_nxt;
    out_rms_r  <= out_rms_nxt;
    out_open_r <= out_open_nxt;
    opa_r      <= opa_nxt;
    opb_r      <= opb_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_mouth_duty     = out_duty_r;
  assign out_rms_level      = out_rms_r;
  assign out_openness_level = out_open_r;

  // Openness stays within 0..1.0.
  `RMSLD_ASSERT_NOW(a_open_range, 1'b1, openness_r <= 17'(ONE_Q16), "openness above one")
  // Block fill never passes the block limit.
  `RMSLD_ASSERT_NOW(a_count_max, 1'b1, count_r <= CNT_W'(MAX_BLOCK), "block count overrun")
  // The serial unit only finishes while the sequencer waits for it.
  `RMSLD_ASSERT_NOW(a_alu_wait, alu_done,
    st_r == ST_SQ_W || st_r == ST_MEAN_W || st_r == ST_ROOT_W || st_r == ST_BM1_W ||
    st_r == ST_BM2_W || st_r == ST_THR_W || st_r == ST_TDIV_W || st_r == ST_OM1_W ||
    st_r == ST_OM2_W || st_r == ST_DUTY_W, "serial unit done outside a wait state")
  // A result leaving the emit state lands in the output register.
  `RMSLD_ASSERT_NEXT(a_emit_load, st_r == ST_EMIT && (!out_valid_r || out_ready),
    out_valid_r && st_r == ST_IDLE, "result not loaded")

endmodule
